[rtl/core/imu_dfc_pkg.sv]
package imu_dfc_pkg;

  // Frame layout: two header bytes, payload, one checksum byte
  localparam int FRAME_BYTES   = 23;
  localparam int PAYLOAD_BYTES = FRAME_BYTES - 3;
  localparam int CHECK_POS     = FRAME_BYTES - 1;
  localparam int FIRST_PAY_POS = 2;
  localparam int NUM_CH        = PAYLOAD_BYTES / 2;

  localparam int POS_W  = 5;
  localparam int CH_W   = 4;
  localparam int PEND_W = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int GAIN_W     = 32;
  localparam int RAW_W      = 16;
  localparam int SCALED_W   = 48;
  localparam int COUNT_W    = 32;

  localparam logic [7:0]        SYNC_FIRST_RST  = 8'd127;
  localparam logic [7:0]        SYNC_SECOND_RST = 8'd128;
  localparam logic [GAIN_W-1:0] GAIN_RST        = 32'd65536;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SYNC_FIRST  = 3'd0,
    CFG_SYNC_SECOND = 3'd1,
    CFG_ACCEL_GAIN  = 3'd2,
    CFG_RATE_GAIN   = 3'd3,
    CFG_ANGLE_GAIN  = 3'd4,
    CFG_TEMP_GAIN   = 3'd5
  } cfg_reg_t;

  typedef enum logic [1:0] {
    PH_SEEK_FIRST  = 2'd0,
    PH_SEEK_SECOND = 2'd1,
    PH_COLLECT     = 2'd2
  } hunt_phase_t;

  typedef logic [NUM_CH-1:0][RAW_W-1:0] word_vec_t;

  // Handoff of one finished frame from parser to emitter
  typedef struct packed {
    logic               load;
    logic               bad;
    logic [COUNT_W-1:0] seen;
    logic [COUNT_W-1:0] nbad;
    word_vec_t          words;
  } frame_t;

  typedef struct packed {
    logic [GAIN_W-1:0] accel;
    logic [GAIN_W-1:0] rate;
    logic [GAIN_W-1:0] angle;
    logic [GAIN_W-1:0] temp;
  } gains_t;

endpackage

[rtl/core/imu_dfc_if.sv]
interface imu_dfc_byte_if;
  import imu_dfc_pkg::*;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface imu_dfc_result_if;
  import imu_dfc_pkg::*;
  logic                       valid;
  logic                       ready;
  logic [CH_W-1:0]            channel;
  logic signed [RAW_W-1:0]    raw_value;
  logic signed [SCALED_W-1:0] scaled_value;
  logic                       last;
  logic                       checksum_bad;
  logic [COUNT_W-1:0]         frames_seen;
  logic [COUNT_W-1:0]         frames_bad;

  modport source (output valid, output channel, output raw_value, output scaled_value,
                  output last, output checksum_bad, output frames_seen,
                  output frames_bad, input ready);
  modport sink   (input valid, input channel, input raw_value, input scaled_value,
                  input last, input checksum_bad, input frames_seen,
                  input frames_bad, output ready);
endinterface

[rtl/core/imu_frame_deframer_checksum_top.sv]
// Channel   Dir  Handshake        Payload
// din       in   valid/ready      data_byte[7:0]
// dout      out  valid/ready      channel, raw_value, scaled_value, last,
//                                 checksum_bad, frames_seen, frames_bad
// cfg       in   cfg_we           cfg_index[2:0], cfg_data[31:0]
//
// One byte is taken every cycle unless the checksum beat stalls; the parser does
// hunt, sum and payload capture in a single register stage.
// A frame end hands the payload to the emitter, which gives one result per cycle
// unless stalled (ten per good frame, one per bad one) via a 16x33 multiplier
// and an output register. The checksum beat waits only while the previous
// frame's results are still being drained, so dout stalls back up into din only
// then. Synchronous reset restores config defaults and clears all control.
module imu_frame_deframer_checksum_top
  import imu_dfc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  imu_dfc_byte_if.sink          din,
  imu_dfc_result_if.source      dout
);

  logic [7:0] sync_first;
  logic [7:0] sync_second;
  gains_t     gains;
  frame_t     frm;
  logic       emit_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_first  <= SYNC_FIRST_RST;
      sync_second <= SYNC_SECOND_RST;
      gains.accel <= GAIN_RST;
      gains.rate  <= GAIN_RST;
      gains.angle <= GAIN_RST;
      gains.temp  <= GAIN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SYNC_FIRST:  sync_first  <= cfg_data[7:0];
        CFG_SYNC_SECOND: sync_second <= cfg_data[7:0];
        CFG_ACCEL_GAIN:  gains.accel <= cfg_data[GAIN_W-1:0];
        CFG_RATE_GAIN:   gains.rate  <= cfg_data[GAIN_W-1:0];
        CFG_ANGLE_GAIN:  gains.angle <= cfg_data[GAIN_W-1:0];
        CFG_TEMP_GAIN:   gains.temp  <= cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  imu_dfc_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .din         (din),
    .sync_first  (sync_first),
    .sync_second (sync_second),
    .emit_busy   (emit_busy),
    .frm         (frm)
  );

  imu_dfc_emitter u_emitter (
    .clk       (clk),
    .rst       (rst),
    .frm       (frm),
    .gains     (gains),
    .emit_busy (emit_busy),
    .dout      (dout)
  );

  a_bad_is_single: assert property (@(posedge clk) disable iff (rst)
    dout.valid && dout.checksum_bad |-> dout.last && dout.channel == '0 &&
    dout.raw_value == '0 && dout.scaled_value == '0)
    else $error("error result malformed");

  a_frame_continues: assert property (@(posedge clk) disable iff (rst)
    dout.valid && !dout.last |=> dout.valid)
    else $error("result stream broke before last beat");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !din.ready |-> emit_busy)
    else $error("input stalled with emitter idle");

  a_load_when_idle: assert property (@(posedge clk) disable iff (rst)
    frm.load |-> !emit_busy)
    else $error("frame handed over while emitter busy");

endmodule

[rtl/core/imu_dfc_parser.sv]
module imu_dfc_parser
  import imu_dfc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  imu_dfc_byte_if.sink        din,
  input  logic [7:0]          sync_first,
  input  logic [7:0]          sync_second,
  input  logic                emit_busy,
  output frame_t              frm
);

  hunt_phase_t        phase, phase_next;
  logic [POS_W-1:0]   pos;
  logic [7:0]         running_sum;
  logic [7:0]         store [PAYLOAD_BYTES];
  logic [COUNT_W-1:0] total_frames;
  logic [COUNT_W-1:0] bad_frames;

  logic       take;
  logic       at_check;
  logic       start_frame;
  logic       pay_shift;
  logic       frame_end;
  logic       sum_bad;
  logic [7:0] b;

  assign b        = din.data_byte;
  assign at_check = (pos == POS_W'(CHECK_POS));
  // stall the checksum beat until the emitter has drained the previous frame
  assign din.ready = !(phase == PH_COLLECT && at_check && emit_busy);
  assign take      = din.valid && din.ready;

  always_comb begin
    phase_next = phase;
    case (phase)
      PH_SEEK_SECOND: begin
        if (take) begin
          if (b == sync_second) phase_next = PH_COLLECT;
          else if (b != sync_first) phase_next = PH_SEEK_FIRST;
        end
      end
      PH_COLLECT: begin
        if (take && at_check) phase_next = PH_SEEK_FIRST;
      end
      default: begin
        if (take) phase_next = (b == sync_first) ? PH_SEEK_SECOND : PH_SEEK_FIRST;
      end
    endcase
  end

  always_comb begin
    start_frame = 1'b0;
    pay_shift   = 1'b0;
    frame_end   = 1'b0;
    case (phase)
      PH_SEEK_SECOND: start_frame = take && (b == sync_second);
      PH_COLLECT: begin
        pay_shift = take && !at_check;
        frame_end = take && at_check;
      end
      default: ;
    endcase
  end

  assign sum_bad = (~running_sum != b);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_SEEK_FIRST;
      pos          <= '0;
      running_sum  <= '0;
      total_frames <= '0;
      bad_frames   <= '0;
    end else begin
      phase <= phase_next;
      if (start_frame) begin
        pos         <= POS_W'(FIRST_PAY_POS);
        running_sum <= '0;
      end else if (pay_shift) begin
        pos         <= pos + POS_W'(1);
        running_sum <= running_sum + b;
      end
      if (frame_end) begin
        total_frames <= total_frames + COUNT_W'(1);
        if (sum_bad) bad_frames <= bad_frames + COUNT_W'(1);
      end
    end
  end

  // payload shifts in from the top; after a full frame entry 0 is the first byte
  always_ff @(posedge clk) begin
    if (pay_shift) begin
      for (int i = 0; i < PAYLOAD_BYTES - 1; i++) store[i] <= store[i+1];
      store[PAYLOAD_BYTES-1] <= b;
    end
  end

  always_comb begin
    frm.load = frame_end;
    frm.bad  = sum_bad;
    frm.seen = total_frames + COUNT_W'(1);
    frm.nbad = sum_bad ? bad_frames + COUNT_W'(1) : bad_frames;
    for (int c = 0; c < NUM_CH; c++) frm.words[c] = {store[2*c+1], store[2*c]};
  end

endmodule

[rtl/core/imu_dfc_emitter.sv]
module imu_dfc_emitter
  import imu_dfc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  frame_t            frm,
  input  gains_t            gains,
  output logic              emit_busy,
  imu_dfc_result_if.source  dout
);

  logic [PEND_W-1:0]  pend;
  logic [CH_W-1:0]    ch;
  word_vec_t          words;
  logic               bad;
  logic [COUNT_W-1:0] seen;
  logic [COUNT_W-1:0] nbad;

  logic                       vld;
  logic [CH_W-1:0]            o_channel;
  logic signed [RAW_W-1:0]    o_raw;
  logic signed [SCALED_W-1:0] o_scaled;
  logic                       o_last;
  logic                       o_bad;
  logic [COUNT_W-1:0]         o_seen;
  logic [COUNT_W-1:0]         o_nbad;

  logic                       step;
  logic [RAW_W-1:0]           raw_sel;
  logic [GAIN_W-1:0]          gain_sel;
  logic signed [SCALED_W:0]   prod;

  assign emit_busy = (pend != '0);
  assign step      = emit_busy && (!vld || dout.ready);
  assign raw_sel   = bad ? '0 : words[0];

  always_comb begin
    case (ch) inside
      [4'd0:4'd2]: gain_sel = gains.accel;
      [4'd3:4'd5]: gain_sel = gains.rate;
      [4'd6:4'd8]: gain_sel = gains.angle;
      default:     gain_sel = gains.temp;
    endcase
  end

  assign prod = $signed(raw_sel) * $signed({1'b0, gain_sel});

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
      vld  <= 1'b0;
    end else begin
      if (frm.load) pend <= frm.bad ? PEND_W'(1) : PEND_W'(NUM_CH);
      else if (step) pend <= pend - PEND_W'(1);
      if (step) vld <= 1'b1;
      else if (dout.ready) vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (frm.load) begin
      ch    <= '0;
      words <= frm.words;
      bad   <= frm.bad;
      seen  <= frm.seen;
      nbad  <= frm.nbad;
    end else if (step) begin
      ch <= ch + CH_W'(1);
      // advance to the next word
      for (int i = 0; i < NUM_CH - 1; i++) words[i] <= words[i+1];
    end
    if (step) begin
      o_channel <= ch;
      o_raw     <= $signed(raw_sel);
      o_scaled  <= prod[SCALED_W-1:0];
      o_last    <= (pend == PEND_W'(1));
      o_bad     <= bad;
      o_seen    <= seen;
      o_nbad    <= nbad;
    end
  end

  assign dout.valid        = vld;
  assign dout.channel      = o_channel;
  assign dout.raw_value    = o_raw;
  assign dout.scaled_value = o_scaled;
  assign dout.last         = o_last;
  assign dout.checksum_bad = o_bad;
  assign dout.frames_seen  = o_seen;
  assign dout.frames_bad   = o_nbad;

endmodule
